// ===== hw/rtl/receiver_command_byte_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Receiver command byte sequencer: assertion macros
// Shared forms for the concurrent checks on the sequencer ports.
// ----------------------------------------------------------------------------
`ifndef RECEIVER_COMMAND_BYTE_SEQUENCER_CORE_MACROS_SVH
`define RECEIVER_COMMAND_BYTE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RCBS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCBS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Receiver command byte sequencer package
// Opcodes, request and status codes, and the work descriptor passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package rcbs_pkg;

	localparam int S_TDATA_W   = 32;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [3:0] OP_ADH = 4'h1;
	localparam logic [3:0] OP_EXE = 4'h2;
	localparam logic [3:0] OP_SRH = 4'h3;
	localparam logic [3:0] OP_ADR = 4'h4;
	localparam logic [3:0] OP_PGE = 4'h5;
	localparam logic [3:0] OP_WRD = 4'h6;
	localparam logic [3:0] OP_RDD = 4'h7;
	localparam logic [3:0] OP_LOC = 4'h8;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_LOCK  = 2'd2;
	localparam logic [1:0] REQ_EXEC  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_PAGE = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;
	localparam logic [1:0] ST_BAD_LOCK = 2'd3;

	localparam logic [3:0] PAGE_LAST = 4'd4;
	localparam logic [3:0] PAGE_REG  = 4'd15;
	localparam logic [3:0] LOCK_MAX  = 4'd3;
	localparam logic [3:0] RDD_ARG   = 4'd1;

	// Step bits, sent lowest first.
	localparam int STEP_PGE   = 0;
	localparam int STEP_SRH_A = 1;
	localparam int STEP_ADR   = 2;
	localparam int STEP_ADH   = 3;
	localparam int STEP_SRH_D = 4;
	localparam int STEP_FIN   = 5;
	localparam int NUM_STEPS  = 6;

	typedef struct packed {
		logic [NUM_STEPS-1:0] steps;
		logic [3:0]           page;
		logic [11:0]          addr;
		logic [3:0]           data_hi;
		logic [7:0]           fin_byte;
		logic                 fin_valid;
		logic                 fin_reply;
		logic [1:0]           status;
	} desc_t;

	// Page size in bytes; zero for pages that do not exist.
	function automatic logic [12:0] page_size(input logic [3:0] pg);
		logic [12:0] sz;
		case (pg)
			4'd0, 4'd1: sz = 13'd256;
			4'd2:       sz = 13'd512;
			4'd3, 4'd4: sz = 13'd4096;
			4'd15:      sz = 13'd8;
			default:    sz = 13'd0;
		endcase
		return sz;
	endfunction

endpackage

// ===== hw/rtl/rcbs_queue.sv =====
// ----------------------------------------------------------------------------
// Descriptor queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module rcbs_queue #(
	parameter int DEPTH = rcbs_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcbs_pkg::desc_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output rcbs_pkg::desc_t pop_data
);
	import rcbs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t             entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rcbs_front.sv =====
// ----------------------------------------------------------------------------
// Request front end
// Checks each request word against the shadow page, address and lock level,
// decides which command bytes it needs and updates the shadows.
// ----------------------------------------------------------------------------
module rcbs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [rcbs_pkg::S_TDATA_W-1:0]   req_data,
	input  logic [rcbs_pkg::S_TUSER_W-1:0]   req_user,
	output rcbs_pkg::desc_t                  desc
);
	import rcbs_pkg::*;

	logic        page_known_q;
	logic [3:0]  shadow_page_q;
	logic        addr_known_q;
	logic [11:0] shadow_addr_q;
	logic [1:0]  shadow_lock_q;

	logic [1:0]  req;
	logic [3:0]  pg;
	logic [11:0] addr;
	logic [7:0]  data;
	logic [3:0]  lvl;
	logic [3:0]  rtn;

	logic        mem_ok;
	logic        lock_set;
	logic        page_send;
	logic        addr_send;

	assign req  = req_user[1:0];
	assign pg   = req_data[3:0];
	assign addr = req_data[15:4];
	assign data = req_data[23:16];
	assign lvl  = req_data[27:24];
	assign rtn  = req_data[31:28];

	assign page_send = !page_known_q || (shadow_page_q != pg);
	assign addr_send = !addr_known_q || (shadow_addr_q != addr);

	always_comb begin
		desc           = '0;
		desc.page      = pg;
		desc.addr      = addr;
		desc.data_hi   = data[7:4];
		mem_ok         = 1'b0;
		lock_set       = 1'b0;
		unique case (req)
			REQ_EXEC: begin
				desc.steps[STEP_FIN] = 1'b1;
				desc.fin_valid       = 1'b1;
				desc.fin_byte        = {OP_EXE, rtn};
			end
			REQ_LOCK: begin
				desc.steps[STEP_FIN] = 1'b1;
				if (lvl > LOCK_MAX) begin
					desc.status = ST_BAD_LOCK;
				end else if (lvl[1:0] != shadow_lock_q) begin
					desc.fin_valid = 1'b1;
					desc.fin_byte  = {OP_LOC, lvl};
					lock_set       = 1'b1;
				end
			end
			REQ_WRITE, REQ_READ: begin
				desc.steps[STEP_FIN] = 1'b1;
				if (!(pg <= PAGE_LAST || pg == PAGE_REG)) begin
					desc.status = ST_BAD_PAGE;
				end else if ({1'b0, addr} >= page_size(pg)) begin
					desc.status = ST_BAD_ADDR;
				end else begin
					mem_ok                  = 1'b1;
					desc.steps[STEP_PGE]    = page_send;
					desc.steps[STEP_SRH_A]  = addr_send;
					desc.steps[STEP_ADR]    = addr_send;
					desc.steps[STEP_ADH]    = addr_send && (addr[11:8] != 4'd0);
					desc.fin_valid          = 1'b1;
					if (req == REQ_WRITE) begin
						desc.steps[STEP_SRH_D] = 1'b1;
						desc.fin_byte          = {OP_WRD, data[3:0]};
					end else begin
						desc.fin_byte  = {OP_RDD, RDD_ARG};
						desc.fin_reply = 1'b1;
					end
				end
			end
			default: begin
				desc.steps[STEP_FIN] = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_known_q  <= 1'b0;
			shadow_page_q <= '0;
			addr_known_q  <= 1'b0;
			shadow_addr_q <= '0;
			shadow_lock_q <= '0;
		end else if (accept) begin
			if (lock_set) begin
				shadow_lock_q <= lvl[1:0];
			end
			if (mem_ok) begin
				page_known_q  <= 1'b1;
				shadow_page_q <= pg;
				// The access moves the address on by one; past the top it is lost.
				shadow_addr_q <= addr + 12'd1;
				addr_known_q  <= (addr != 12'hfff);
			end
		end
	end

endmodule

// ===== hw/rtl/rcbs_back.sv =====
// ----------------------------------------------------------------------------
// Command back end
// Takes descriptors from the queue and sends their command bytes one word
// per cycle, while the output accepts them, through a registered output stage.
// ----------------------------------------------------------------------------
module rcbs_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_not_empty,
	input  rcbs_pkg::desc_t                  q_data,
	output logic                             q_pop,
	output logic                             m_valid,
	input  logic                             m_ready,
	output logic [rcbs_pkg::M_TDATA_W-1:0]   m_data,
	output logic                             m_last
);
	import rcbs_pkg::*;

	desc_t                cur_q;
	logic [NUM_STEPS-1:0] steps_q;
	logic                 m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic                 m_last_q;

	logic                 out_free;
	logic                 busy;
	logic [NUM_STEPS-1:0] sel;
	logic [NUM_STEPS-1:0] remaining;
	logic                 emit;
	logic                 cmd_valid;
	logic [7:0]           cmd_byte;
	logic                 reply;
	logic [1:0]           status;

	assign out_free  = !m_valid_q || m_ready;
	assign busy      = (steps_q != '0);
	assign sel       = steps_q & (~steps_q + 1'b1);
	assign remaining = steps_q & ~sel;
	assign emit      = out_free && busy;
	assign q_pop     = q_not_empty && (!busy || (emit && remaining == '0));

	always_comb begin
		cmd_valid = 1'b1;
		reply     = 1'b0;
		status    = ST_OK;
		cmd_byte  = cur_q.fin_byte;
		if (sel[STEP_PGE]) begin
			cmd_byte = {OP_PGE, cur_q.page};
		end else if (sel[STEP_SRH_A]) begin
			cmd_byte = {OP_SRH, cur_q.addr[7:4]};
		end else if (sel[STEP_ADR]) begin
			cmd_byte = {OP_ADR, cur_q.addr[3:0]};
		end else if (sel[STEP_ADH]) begin
			cmd_byte = {OP_ADH, cur_q.addr[11:8]};
		end else if (sel[STEP_SRH_D]) begin
			cmd_byte = {OP_SRH, cur_q.data_hi};
		end else begin
			cmd_valid = cur_q.fin_valid;
			reply     = cur_q.fin_reply;
			status    = cur_q.status;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (emit) begin
			m_data_q <= {4'd0, status, reply, cmd_byte, cmd_valid};
			m_last_q <= (remaining == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				steps_q <= q_data.steps;
			end else if (emit) begin
				steps_q <= remaining;
			end
			if (out_free) begin
				m_valid_q <= busy;
			end
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = m_data_q;
	assign m_last  = m_last_q;

endmodule

// ===== hw/rtl/receiver_command_byte_sequencer_core.sv =====
// An accepted request word passes from the descriptor queue to the back end's current
// descriptor, then to the registered output stage. One command word per cycle leaves
// the single output port while m_axis_tready is high; a request gives 1 to 6 words.
// The descriptor queue lets requests keep arriving while the output is stalled.
// Reset (arst_n low, asynchronous): shadows unknown, lock level zero, queue empty.
// ----------------------------------------------------------------------------
// Receiver command byte sequencer
// Turns memory, lock and routine requests into nibble command bytes for a
// receiver's remote interface, skipping page and address commands that the
// shadow copies show to be redundant.
// ----------------------------------------------------------------------------
module receiver_command_byte_sequencer_core #(
	parameter int QUEUE_DEPTH = rcbs_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [3:0] page, [15:4] mem_addr, [23:16] wr_data, [27:24] lock_level, [31:28] routine
	input  logic [rcbs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// [1:0] req_type
	input  logic [rcbs_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] cmd_valid, [8:1] cmd_byte, [9] expect_reply, [11:10] status, [15:12] zero
	output logic [rcbs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	output logic                             m_axis_tlast
);
	import rcbs_pkg::*;

	desc_t front_desc;
	desc_t queue_desc;
	logic  queue_full;
	logic  queue_not_empty;
	logic  queue_pop;
	logic  accept;

	assign s_axis_tready = !queue_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	rcbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_data (s_axis_tdata),
		.req_user (s_axis_tuser),
		.desc     (front_desc)
	);

	rcbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_desc),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_not_empty),
		.pop_data  (queue_desc)
	);

	rcbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (queue_not_empty),
		.q_data      (queue_desc),
		.q_pop       (queue_pop),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_data      (m_axis_tdata),
		.m_last      (m_axis_tlast)
	);

endmodule

// ===== hw/rtl/rcbs_checker.sv =====
// ----------------------------------------------------------------------------
// Receiver command byte sequencer checker
// Port-level checks on the command word stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "receiver_command_byte_sequencer_core_macros.svh"

module rcbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	import rcbs_pkg::*;

	// A stalled word holds.
	`RCBS_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")

	// A word with no command is always the only word of its request.
	`RCBS_ASSERT_IMP(a_nocmd_last, clk, arst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tlast, "empty word is not last")

	// An error word carries no command and a zero byte.
	`RCBS_ASSERT_IMP(a_err_empty, clk, arst_n, m_axis_tvalid && m_axis_tdata[11:10] != ST_OK, !m_axis_tdata[0] && m_axis_tdata[8:1] == 8'h00, "error word carries a command")

	// Only the final read command expects a reply.
	`RCBS_ASSERT_IMP(a_reply_rdd, clk, arst_n, m_axis_tvalid && m_axis_tdata[9], m_axis_tlast && (m_axis_tdata[8:1] == ({OP_RDD, RDD_ARG})), "reply expected on a non-read word")

endmodule

bind receiver_command_byte_sequencer_core rcbs_checker u_rcbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receiver command byte sequencer testbench
// Drives write, read, lock and execute requests into the request stream and
// checks every command word against a typed table row or a shadow-tracking
// predictor. A short table of directed requests comes first, then random
// requests with varied idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
	import rcbs_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 95;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  page;
		logic [11:0] addr;
		logic [7:0]  data;
		logic [3:0]  lvl;
		logic [3:0]  rtn;
	} req_t;

	// Same layout as m_axis_tdata, from the top bit down.
	typedef struct packed {
		logic [3:0] pad;
		logic [1:0] status;
		logic       reply;
		logic [7:0] cmd;
		logic       cmd_ok;
	} cmd_word_t;

	typedef struct packed {
		logic      last;
		cmd_word_t w;
	} cmd_exp_t;

	typedef struct {
		req_t      rq;
		bit        typed;
		cmd_word_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	// Shadow copy of the sequencer state.
	bit          pg_known;
	logic [3:0]  sh_page;
	bit          ad_known;
	logic [11:0] sh_addr;
	logic [1:0]  sh_lock;

	cmd_exp_t burst[$];
	cmd_exp_t cmd_q[$];
	dir_row_t plan[$];

	int src_idle;
	int snk_idle;
	bit hold_out;
	int idle_cycles;
	int mismatches;
	int words_checked;
	int n_sent, n_write, n_read, n_lock, n_exec, n_reject, n_wraps;
	cmd_word_t seen;
	cmd_exp_t  head;

	receiver_command_byte_sequencer_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	function automatic int page_span(input logic [3:0] pg);
		case (pg)
			4'd0, 4'd1: return 256;
			4'd2:       return 512;
			4'd3, 4'd4: return 4096;
			4'd15:      return 8;
			default:    return 0;
		endcase
	endfunction

	function automatic void emit(input logic ok, input logic [7:0] cmd, input logic reply,
			input logic [1:0] status);
		cmd_exp_t e;
		e.last     = 1'b0;
		e.w.pad    = 4'h0;
		e.w.status = status;
		e.w.reply  = reply;
		e.w.cmd    = cmd;
		e.w.cmd_ok = ok;
		burst.push_back(e);
	endfunction

	// Expands one request into its command words and advances the shadows.
	function automatic void expand_request(input req_t r);
		int span;
		burst.delete();
		case (r.op)
			REQ_EXEC: emit(1'b1, {OP_EXE, r.rtn}, 1'b0, ST_OK);
			REQ_LOCK: begin
				if (r.lvl > LOCK_MAX) begin
					emit(1'b0, 8'h00, 1'b0, ST_BAD_LOCK);
				end else if (r.lvl[1:0] != sh_lock) begin
					emit(1'b1, {OP_LOC, r.lvl}, 1'b0, ST_OK);
					sh_lock = r.lvl[1:0];
				end else begin
					emit(1'b0, 8'h00, 1'b0, ST_OK);
				end
			end
			default: begin
				span = page_span(r.page);
				if (span == 0) begin
					emit(1'b0, 8'h00, 1'b0, ST_BAD_PAGE);
				end else if (int'(r.addr) >= span) begin
					emit(1'b0, 8'h00, 1'b0, ST_BAD_ADDR);
				end else begin
					if (!pg_known || sh_page != r.page) begin
						emit(1'b1, {OP_PGE, r.page}, 1'b0, ST_OK);
						sh_page  = r.page;
						pg_known = 1'b1;
					end
					if (!ad_known || sh_addr != r.addr) begin
						emit(1'b1, {OP_SRH, r.addr[7:4]}, 1'b0, ST_OK);
						emit(1'b1, {OP_ADR, r.addr[3:0]}, 1'b0, ST_OK);
						if (r.addr > 12'h0ff)
							emit(1'b1, {OP_ADH, r.addr[11:8]}, 1'b0, ST_OK);
						sh_addr  = r.addr;
						ad_known = 1'b1;
					end
					if (r.op == REQ_WRITE) begin
						emit(1'b1, {OP_SRH, r.data[7:4]}, 1'b0, ST_OK);
						emit(1'b1, {OP_WRD, r.data[3:0]}, 1'b0, ST_OK);
					end else begin
						emit(1'b1, {OP_RDD, RDD_ARG}, 1'b1, ST_OK);
					end
					// Running off the top of the address space leaves the address unknown.
					if (sh_addr == 12'hfff) begin
						sh_addr  = 12'h000;
						ad_known = 1'b0;
						n_wraps++;
					end else begin
						sh_addr = sh_addr + 12'd1;
					end
				end
			end
		endcase
		burst[burst.size()-1].last = 1'b1;
	endfunction

	function automatic void add_row(input logic [1:0] op, input logic [3:0] pg,
			input logic [11:0] addr, input logic [7:0] data, input logic [3:0] lvl,
			input logic [3:0] rtn, input bit typed, input logic [1:0] st,
			input logic [7:0] cmd);
		dir_row_t row;
		row.rq.op          = op;
		row.rq.page        = pg;
		row.rq.addr        = addr;
		row.rq.data        = data;
		row.rq.lvl         = lvl;
		row.rq.rtn         = rtn;
		row.typed          = typed;
		row.want.pad       = 4'h0;
		row.want.status    = st;
		row.want.reply     = 1'b0;
		row.want.cmd       = cmd;
		row.want.cmd_ok    = |cmd;
		plan.push_back(row);
	endfunction

	task automatic offer(input req_t r, input bit typed, input cmd_word_t want);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.rtn, r.lvl, r.data, r.addr, r.page};
		s_axis_tuser  <= r.op;
		do @(posedge clk); while (!s_axis_tready);
		expand_request(r);
		if (typed) begin
			cmd_q.push_back({1'b1, want});
		end else begin
			foreach (burst[i]) cmd_q.push_back(burst[i]);
		end
		n_sent++;
		case (r.op)
			REQ_WRITE: n_write++;
			REQ_READ:  n_read++;
			REQ_LOCK:  n_lock++;
			default:   n_exec++;
		endcase
		if (burst[0].w.status != ST_OK)
			n_reject++;
	endtask

	// Mostly well-formed accesses that follow on from the shadow address, plus noise.
	task automatic pick_random(output req_t r);
		int sel;
		int span;
		int c;
		r.op   = 2'($urandom_range(3));
		r.page = 4'($urandom_range(15));
		r.addr = 12'($urandom_range(4095));
		r.data = 8'($urandom_range(255));
		r.lvl  = 4'($urandom_range(15));
		r.rtn  = 4'($urandom_range(15));
		sel = $urandom_range(99);
		if (sel < 55) begin
			r.op = $urandom_range(1) ? REQ_READ : REQ_WRITE;
			if (pg_known && $urandom_range(99) < 60) begin
				r.page = sh_page;
			end else begin
				c = $urandom_range(5);
				r.page = (c == 5) ? PAGE_REG : 4'(c);
			end
			span = page_span(r.page);
			c = $urandom_range(9);
			if (c < 5 && ad_known && int'(sh_addr) < span)
				r.addr = sh_addr;
			else if (c < 7)
				r.addr = 12'(span - 1 - $urandom_range(2));
			else
				r.addr = 12'($urandom_range(span - 1));
		end else if (sel < 67) begin
			r.op = REQ_LOCK;
			if ($urandom_range(99) < 80)
				r.lvl = 4'($urandom_range(3));
		end else if (sel < 77) begin
			r.op = REQ_EXEC;
		end else if (sel < 88) begin
			r.op = $urandom_range(1) ? REQ_READ : REQ_WRITE;
			c = $urandom_range(3);
			r.page = (c == 3) ? PAGE_REG : 4'(c);
			r.addr = 12'($urandom_range(4095, page_span(r.page)));
		end else begin
			r.op   = $urandom_range(1) ? REQ_READ : REQ_WRITE;
			r.page = 4'($urandom_range(14, 5));
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = cmd_word_t'(m_axis_tdata);
			if (cmd_q.size() == 0) begin
				mismatches++;
				$display("%0t ns: command word %h (last %b) with none expected, expected nothing",
					$time, m_axis_tdata, m_axis_tlast);
			end else begin
				head = cmd_q.pop_front();
				words_checked++;
				check_field("cmd_valid", head.w.cmd_ok, seen.cmd_ok);
				check_field("cmd_byte", head.w.cmd, seen.cmd);
				check_field("expect_reply", head.w.reply, seen.reply);
				check_field("status", head.w.status, seen.status);
				check_field("pad bits", head.w.pad, seen.pad);
				check_field("last", head.last, m_axis_tlast);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles, %0d words still expected",
				$time, STALL_LIMIT, cmd_q.size());
			$display("receiver_command_byte_sequencer_core test failed");
			$finish;
		end
	end

	// Output side: random backpressure, or one long hold-off when asked.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	initial begin
		req_t r;
		cmd_word_t none;
		none          = '0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		hold_out      = 1'b0;
		idle_cycles   = 0;
		src_idle      = 28;
		snk_idle      = 55;

		// Requests after reset, rejects and the edges of each page.
		add_row(REQ_LOCK,  4'h0, 12'h000, 8'h00, 4'd0,  4'h0, 1, ST_OK, 8'h00);
		add_row(REQ_LOCK,  4'h7, 12'h5a5, 8'h3c, 4'd15, 4'h9, 1, ST_BAD_LOCK, 8'h00);
		add_row(REQ_LOCK,  4'h0, 12'h000, 8'h00, 4'd4,  4'h0, 1, ST_BAD_LOCK, 8'h00);
		add_row(REQ_LOCK,  4'h0, 12'h000, 8'h00, 4'd3,  4'h0, 1, ST_OK, {OP_LOC, 4'd3});
		add_row(REQ_EXEC,  4'h0, 12'h000, 8'h00, 4'd0,  4'h0, 1, ST_OK, {OP_EXE, 4'h0});
		add_row(REQ_EXEC,  4'hf, 12'hfff, 8'hff, 4'hf,  4'hf, 1, ST_OK, {OP_EXE, 4'hf});
		add_row(REQ_WRITE, 4'd5, 12'h000, 8'h11, 4'd0,  4'h0, 1, ST_BAD_PAGE, 8'h00);
		add_row(REQ_READ,  4'd14, 12'hfff, 8'h00, 4'd0, 4'h0, 1, ST_BAD_PAGE, 8'h00);
		add_row(REQ_WRITE, 4'd0, 12'd256, 8'h22, 4'd0,  4'h0, 1, ST_BAD_ADDR, 8'h00);
		add_row(REQ_READ,  4'd15, 12'd8,  8'h00, 4'd0,  4'h0, 1, ST_BAD_ADDR, 8'h00);
		add_row(REQ_WRITE, 4'd2, 12'hfff, 8'h00, 4'd0,  4'h0, 1, ST_BAD_ADDR, 8'h00);
		add_row(REQ_WRITE, 4'd0, 12'h000, 8'hff, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_READ,  4'd0, 12'h001, 8'h00, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_WRITE, 4'd4, 12'hfff, 8'h00, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_READ,  4'd4, 12'h000, 8'h00, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_READ,  4'd3, 12'h001, 8'h00, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_WRITE, 4'd15, 12'd7,  8'h5a, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_READ,  4'd15, 12'd0,  8'h00, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_WRITE, 4'd2, 12'd511, 8'ha5, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_LOCK,  4'h0, 12'h000, 8'h00, 4'd3,  4'h0, 1, ST_OK, 8'h00);
		add_row(REQ_LOCK,  4'h0, 12'h000, 8'h00, 4'd1,  4'h0, 1, ST_OK, {OP_LOC, 4'd1});
		add_row(REQ_READ,  4'd1, 12'd255, 8'h00, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_EXEC,  4'h0, 12'h000, 8'h00, 4'd0,  4'ha, 1, ST_OK, {OP_EXE, 4'ha});
		add_row(REQ_WRITE, 4'd3, 12'hffe, 8'h3c, 4'd0,  4'h0, 0, ST_OK, 8'h00);
		add_row(REQ_WRITE, 4'd3, 12'hfff, 8'hc3, 4'd0,  4'h0, 0, ST_OK, 8'h00);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) offer(plan[i].rq, plan[i].typed, plan[i].want);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin src_idle = 28; snk_idle = 55; end
				1: begin src_idle = 55; snk_idle = 28; end
				default: begin
					src_idle = 0;
					snk_idle = 0;
					// The sender keeps offering while the output is held, so the queue fills.
					hold_out = 1'b1;
				end
			endcase
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				pick_random(r);
				offer(r, 1'b0, none);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (cmd_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("Covered %0d requests: %0d writes, %0d reads, %0d lock, %0d execute, %0d rejected.",
			n_sent, n_write, n_read, n_lock, n_exec, n_reject);
		$display("Checked %0d command words, %0d address wraps, one long output hold-off.",
			words_checked, n_wraps);
		if (mismatches == 0 && cmd_q.size() == 0)
			$display("receiver_command_byte_sequencer_core test passed");
		else
			$display("receiver_command_byte_sequencer_core test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rcbs_pkg.sv
hw/rtl/rcbs_queue.sv
hw/rtl/rcbs_front.sv
hw/rtl/rcbs_back.sv
hw/rtl/receiver_command_byte_sequencer_core.sv
hw/rtl/rcbs_checker.sv
tb/tb.sv
